// File: rtl/mrv_pkg.sv
// Shared types and constants for the manifest record validator.
package mrv_pkg;

   localparam int FIXED_BYTES = 30;
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;

   localparam logic [3:0] PH_MAGIC  = 4'd0;
   localparam logic [3:0] PH_VER    = 4'd1;
   localparam logic [3:0] PH_LEN    = 4'd2;
   localparam logic [3:0] PH_EPOCH  = 4'd3;
   localparam logic [3:0] PH_NEXT   = 4'd4;
   localparam logic [3:0] PH_COUNT  = 4'd5;
   localparam logic [3:0] PH_RSTART = 4'd6;
   localparam logic [3:0] PH_REND   = 4'd7;
   localparam logic [3:0] PH_TAIL   = 4'd8;
   localparam logic [3:0] PH_CRC    = 4'd9;
   localparam logic [3:0] PH_FOOTER = 4'd10;
   localparam logic [3:0] PH_DONE   = 4'd11;
   localparam logic [3:0] PH_SKIP   = 4'd12;

   localparam logic [3:0] ST_OK      = 4'd0;
   localparam logic [3:0] ST_SHORT   = 4'd1;
   localparam logic [3:0] ST_MAGIC   = 4'd2;
   localparam logic [3:0] ST_VERSION = 4'd3;
   localparam logic [3:0] ST_MANY    = 4'd4;
   localparam logic [3:0] ST_LENGTH  = 4'd5;
   localparam logic [3:0] ST_SIZE    = 4'd6;
   localparam logic [3:0] ST_START0  = 4'd7;
   localparam logic [3:0] ST_ORDER   = 4'd8;
   localparam logic [3:0] ST_TAIL0   = 4'd9;
   localparam logic [3:0] ST_CRC     = 4'd10;
   localparam logic [3:0] ST_FOOTER  = 4'd11;

   localparam logic [1:0] CSR_MAGIC   = 2'd0;
   localparam logic [1:0] CSR_VERSION = 2'd1;
   localparam logic [1:0] CSR_FOOTER  = 2'd2;
   localparam logic [1:0] CSR_MAXRNG  = 2'd3;

   // One result, as it leaves the parser and sits in the queue.
   typedef struct packed {
      logic        item_kind;
      logic [12:0] range_index;
      logic [31:0] range_start;
      logic [31:0] range_end;
      logic [3:0]  status;
      logic [31:0] epoch;
      logic [31:0] next_generation;
      logic [31:0] tail_generation;
      logic [15:0] range_total;
      logic        final_res;
   } result_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
      logic [31:0] c;
      c = c_in ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

endpackage

// File: rtl/manifest_record_validator.sv
// Top level of the manifest record validator: configuration, parser and result queue.
//
// Usage: a record enters one byte per req_ item; tdata carries data_byte and
// tlast marks end_of_record on the last byte. Each range pair that completes
// with no error seen yields a provisional rsp_ item (kind 0); the end byte
// yields a summary item (kind 1) with the status code, and then the record
// state clears for the next record. Registers are written through csr_, and
// the user must write them only while the block is idle; the block itself does
// not enforce this. Results are registered in the queue before they leave on rsp_.
// Throughput: one byte per cycle while req_tready is high; the byte-wise CRC and
// field checks of the parser set that figure. Results wait in a four-entry queue;
// req_tready drops only while fewer than two entries are free, so a stalled
// receiver holds the input back once the queue fills, and nothing is lost.
// Reset clears the parse state, the queue and the registers (max_ranges to 64).
module manifest_record_validator
   import mrv_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte[7:0]
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // range_index[12:0], range_start[44:13], range_end[76:45], status[80:77],
   // epoch[112:81], next_generation[144:113], tail_generation[176:145],
   // range_total[192:177], zero fill[199:193]
   output logic [199:0] rsp_tdata,
   output logic         rsp_tuser,   // item_kind
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [31:0] magic_ff, footer_ff;
   logic [15:0] version_ff;
   logic [12:0] maxr_ff;
   logic        acc;
   logic        r0v, r1v;
   result_type  r0, r1, q;
   logic [CW-1:0] used;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= '0;
         version_ff <= '0;
         footer_ff <= '0;
         maxr_ff <= 13'd64;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAGIC:   magic_ff <= csr_wdata;
            CSR_VERSION: version_ff <= csr_wdata[15:0];
            CSR_FOOTER:  footer_ff <= csr_wdata;
            CSR_MAXRNG:  maxr_ff <= csr_wdata[12:0];
            default:     magic_ff <= magic_ff;
         endcase
      end
   end

   assign req_tready = (used <= CW'(QUEUE_DEPTH - 2));
   assign acc = req_tvalid && req_tready;

   mrv_parser u_parser (
      .clock(clock), .reset(reset), .byte_valid(acc), .data_byte(req_tdata),
      .end_of_record(req_tlast), .cfg_magic(magic_ff), .cfg_version(version_ff),
      .cfg_footer(footer_ff), .cfg_max_ranges(maxr_ff),
      .res0_valid(r0v), .res0(r0), .res1_valid(r1v), .res1(r1)
   );

   mrv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .wr0_valid(r0v), .wr0(r0), .wr1_valid(r1v),
      .wr1(r1), .used(used), .rd_valid(rsp_tvalid), .rd(q), .rd_ready(rsp_tready)
   );

   assign rsp_tdata = {7'd0, q.range_total, q.tail_generation, q.next_generation,
                       q.epoch, q.status, q.range_end, q.range_start, q.range_index};
   assign rsp_tuser = q.item_kind;
   assign rsp_tlast = q.final_res;

   // The queue never overflows.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      used <= CW'(QUEUE_DEPTH)) else $error("result queue overflow");
   // A summary is always the last result of its byte.
   a_summary_final: assert property (@(posedge clock) disable iff (reset)
      r1v |-> r1.final_res) else $error("summary not final");
   // A range result is issued only with a byte accepted.
   a_range_acc: assert property (@(posedge clock) disable iff (reset)
      r0v |-> acc) else $error("range result without input");

endmodule

// File: rtl/mrv_parser.sv
// Front part: parses bytes, runs the CRC and checks, and produces up to two results.
module mrv_parser
   import mrv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        byte_valid,
   input  logic [7:0]  data_byte,
   input  logic        end_of_record,
   input  logic [31:0] cfg_magic,
   input  logic [15:0] cfg_version,
   input  logic [31:0] cfg_footer,
   input  logic [12:0] cfg_max_ranges,
   output logic        res0_valid,
   output result_type  res0,
   output logic        res1_valid,
   output result_type  res1
);

   logic [16:0] byte_count_ff, byte_count_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] crc_tail_ff, crc_tail_in;
   logic [3:0]  phase_ff, phase_in;
   logic [3:0]  err_ff, err_in;
   logic [15:0] len_ff, len_in;
   logic [31:0] epoch_ff, epoch_in;
   logic [31:0] next_ff, next_in;
   logic [15:0] count_ff, count_in;
   logic [12:0] done_ff, done_in;
   logic [31:0] pstart_ff, pstart_in;
   logic [31:0] tail_ff, tail_in;
   logic [1:0]  pos_ff, pos_in;

   logic        range_out;
   logic [31:0] word;
   logic [15:0] half;
   logic [1:0]  need;
   logic [12:0] done_inc;
   logic [3:0]  sum_status;
   logic [15:0] exp_len;

   always_comb begin
      byte_count_in = byte_count_ff;
      shift_in = shift_ff;
      crc_in = crc_ff;
      crc_tail_in = crc_tail_ff;
      phase_in = phase_ff;
      err_in = err_ff;
      len_in = len_ff;
      epoch_in = epoch_ff;
      next_in = next_ff;
      count_in = count_ff;
      done_in = done_ff;
      pstart_in = pstart_ff;
      tail_in = tail_ff;
      pos_in = pos_ff;
      range_out = 1'b0;
      word = {data_byte, shift_ff[31:8]};
      half = word[31:16];
      need = (phase_ff == PH_VER || phase_ff == PH_LEN || phase_ff == PH_COUNT) ?
             2'd2 : 2'd0;
      done_inc = done_ff + 13'd1;
      exp_len = 16'(FIXED_BYTES) + {half[12:0], 3'b000};
      sum_status = ST_OK;

      if (byte_valid) begin
         if (!byte_count_ff[16]) byte_count_in = byte_count_ff + 17'd1;
         if (phase_ff <= PH_TAIL) crc_in = crc_byte(crc_ff, data_byte);
         if (phase_ff < PH_DONE) begin
            shift_in = word;
            pos_in = pos_ff + 2'd1;
            if (pos_in == need) begin
               pos_in = 2'd0;
               case (phase_ff)
                  PH_MAGIC: begin
                     if (word != cfg_magic && err_in == ST_OK) err_in = ST_MAGIC;
                     phase_in = PH_VER;
                  end
                  PH_VER: begin
                     if (half != cfg_version && err_in == ST_OK) err_in = ST_VERSION;
                     phase_in = PH_LEN;
                  end
                  PH_LEN: begin
                     len_in = half;
                     phase_in = PH_EPOCH;
                  end
                  PH_EPOCH: begin
                     epoch_in = word;
                     phase_in = PH_NEXT;
                  end
                  PH_NEXT: begin
                     next_in = word;
                     phase_in = PH_COUNT;
                  end
                  PH_COUNT: begin
                     count_in = half;
                     if (half > {3'd0, cfg_max_ranges}) begin
                        if (err_in == ST_OK) err_in = ST_MANY;
                        phase_in = PH_SKIP;
                     end else begin
                        if (len_ff != exp_len && err_in == ST_OK) err_in = ST_LENGTH;
                        phase_in = (half == 16'd0) ? PH_TAIL : PH_RSTART;
                     end
                  end
                  PH_RSTART: begin
                     pstart_in = word;
                     phase_in = PH_REND;
                  end
                  PH_REND: begin
                     if (err_in == ST_OK) begin
                        if (pstart_ff == 32'd0) err_in = ST_START0;
                        else if (word < pstart_ff) err_in = ST_ORDER;
                     end
                     range_out = (err_in == ST_OK);
                     done_in = done_inc;
                     phase_in = ({3'd0, done_inc} == count_ff) ? PH_TAIL : PH_RSTART;
                  end
                  PH_TAIL: begin
                     tail_in = word;
                     if (word == 32'd0 && count_ff != 16'd0 && err_in == ST_OK)
                        err_in = ST_TAIL0;
                     crc_tail_in = ~crc_in;
                     phase_in = PH_CRC;
                  end
                  PH_CRC: begin
                     if (word != crc_tail_ff && err_in == ST_OK) err_in = ST_CRC;
                     phase_in = PH_FOOTER;
                  end
                  default: begin
                     if (word != cfg_footer && err_in == ST_OK) err_in = ST_FOOTER;
                     phase_in = PH_DONE;
                  end
               endcase
            end
         end

         if (byte_count_in < 17'(FIXED_BYTES)) sum_status = ST_SHORT;
         else if (err_in inside {[ST_MAGIC:ST_LENGTH]}) sum_status = err_in;
         else if (byte_count_in != {1'b0, len_in}) sum_status = ST_SIZE;
         else sum_status = err_in;

         if (end_of_record) begin
            byte_count_in = '0;
            shift_in = '0;
            crc_in = '1;
            crc_tail_in = '0;
            phase_in = PH_MAGIC;
            err_in = ST_OK;
            len_in = '0;
            epoch_in = '0;
            next_in = '0;
            count_in = '0;
            done_in = '0;
            pstart_in = '0;
            tail_in = '0;
            pos_in = '0;
         end
      end
   end

   // Results use the field values as they stand after this byte; range_index counts the ranges before it.
   always_comb begin
      res0 = '0;
      res1 = '0;
      res0_valid = 1'b0;
      res1_valid = 1'b0;
      if (byte_valid && range_out) begin
         res0_valid = 1'b1;
         res0.item_kind = 1'b0;
         res0.range_index = done_ff;
         res0.range_start = pstart_ff;
         res0.range_end = word;
         res0.epoch = epoch_ff;
         res0.next_generation = next_ff;
         res0.range_total = count_ff;
         res0.final_res = !end_of_record;
      end
      if (byte_valid && end_of_record) begin
         res1_valid = 1'b1;
         res1.item_kind = 1'b1;
         res1.status = sum_status;
         res1.epoch = epoch_ff;
         res1.next_generation = next_ff;
         res1.range_total = count_ff;
         res1.final_res = 1'b1;
         // Fields completing on the end byte itself.
         if (phase_ff == PH_EPOCH && pos_ff == 2'd3) res1.epoch = word;
         if (phase_ff == PH_NEXT && pos_ff == 2'd3) res1.next_generation = word;
         if (phase_ff == PH_COUNT && pos_ff == 2'd1) res1.range_total = half;
         if (phase_ff == PH_TAIL && pos_ff == 2'd3) res1.tail_generation = word;
         else res1.tail_generation = tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         shift_ff <= '0;
         crc_ff <= '1;
         crc_tail_ff <= '0;
         phase_ff <= PH_MAGIC;
         err_ff <= ST_OK;
         len_ff <= '0;
         epoch_ff <= '0;
         next_ff <= '0;
         count_ff <= '0;
         done_ff <= '0;
         pstart_ff <= '0;
         tail_ff <= '0;
         pos_ff <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         shift_ff <= shift_in;
         crc_ff <= crc_in;
         crc_tail_ff <= crc_tail_in;
         phase_ff <= phase_in;
         err_ff <= err_in;
         len_ff <= len_in;
         epoch_ff <= epoch_in;
         next_ff <= next_in;
         count_ff <= count_in;
         done_ff <= done_in;
         pstart_ff <= pstart_in;
         tail_ff <= tail_in;
         pos_ff <= pos_in;
      end
   end

endmodule

// File: rtl/mrv_queue.sv
// Result queue between the parser and the output port; takes up to two items a cycle.
module mrv_queue
   import mrv_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       wr0_valid,
   input  result_type wr0,
   input  logic       wr1_valid,
   input  result_type wr1,
   output logic [$clog2(DEPTH+1)-1:0] used,
   output logic       rd_valid,
   output result_type rd,
   input  logic       rd_ready
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   result_type  mem_ff [DEPTH];
   logic [AW-1:0] wptr_ff, rptr_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] wsel;
   logic          pop;

   assign pop = rd_valid && rd_ready;
   assign rd_valid = (cnt_ff != '0);
   assign rd = mem_ff[rptr_ff];
   assign used = cnt_ff;
   assign wsel = wr0_valid ? AW'(wptr_ff + AW'(1)) : wptr_ff;

   always_comb begin
      cnt_in = cnt_ff + CW'(wr0_valid) + CW'(wr1_valid) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (wr0_valid) mem_ff[wptr_ff] <= wr0;
      if (wr1_valid) mem_ff[wsel] <= wr1;
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wptr_ff <= AW'(wptr_ff + AW'(wr0_valid) + AW'(wr1_valid));
         if (pop) rptr_ff <= AW'(rptr_ff + AW'(1));
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: bench/manifest_record_validator_tb.sv
// Self-checking testbench for the manifest record validator.
`timescale 1ns / 100ps

module manifest_record_validator_tb;
   import mrv_pkg::*;

   typedef struct packed {
      logic        kind;
      logic [12:0] index;
      logic [31:0] rstart;
      logic [31:0] rend;
      logic [3:0]  status;
      logic [31:0] epoch;
      logic [31:0] next_gen;
      logic [31:0] tail_gen;
      logic [15:0] total;
      logic        final_res;
   } manifest_result_type;

   // Follows the record parse byte by byte and holds the results still to arrive.
   class manifest_scoreboard;
      logic [31:0] magic_reg, version_reg, footer_reg, max_reg;
      logic [16:0] nbytes;
      logic [31:0] shift, crc, crc_tail, epoch_v, next_v, pend_start, tail_v;
      logic [3:0]  phase, err;
      logic [15:0] len_v, count_v;
      logic [12:0] done_cnt;
      logic [1:0]  fpos;
      manifest_result_type pending_results[$];
      int errors;

      function void clear_record();
         nbytes = 0; shift = 0; crc = '1; crc_tail = 0; phase = PH_MAGIC;
         err = ST_OK; len_v = 0; epoch_v = 0; next_v = 0; count_v = 0;
         done_cnt = 0; pend_start = 0; tail_v = 0; fpos = 0;
      endfunction

      function void reset_all();
         magic_reg = 0; version_reg = 0; footer_reg = 0; max_reg = 64;
         errors = 0;
         clear_record();
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] v);
         case (idx)
            CSR_MAGIC:   magic_reg = v;
            CSR_VERSION: version_reg = v & 32'hFFFF;
            CSR_FOOTER:  footer_reg = v;
            default:     max_reg = v & 32'h1FFF;
         endcase
      endfunction

      function void flag(logic [3:0] code);
         if (err == ST_OK) err = code;
      endfunction

      function void push(logic kind, logic [12:0] idx, logic [31:0] rs, logic [31:0] re,
                         logic [3:0] st, logic [31:0] tl);
         manifest_result_type r;
         r.kind = kind; r.index = idx; r.rstart = rs; r.rend = re; r.status = st;
         r.epoch = epoch_v; r.next_gen = next_v; r.tail_gen = tl; r.total = count_v;
         r.final_res = 0;
         pending_results = {pending_results, r};
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         logic [2:0] need;
         logic [31:0] c;
         logic [3:0] st;
         int n0;
         n0 = pending_results.size();
         if (nbytes < 17'd65536) nbytes++;
         if (phase <= PH_TAIL) begin
            c = crc ^ {24'd0, b};
            for (int i = 0; i < 8; i++) c = (c >> 1) ^ (c[0] ? 32'hEDB88320 : 32'd0);
            crc = c;
         end
         if (phase < PH_DONE) begin
            need = (phase == PH_VER || phase == PH_LEN || phase == PH_COUNT) ? 2 : 4;
            shift = {b, shift[31:8]};
            fpos = fpos + 1;
            if (fpos == need[1:0]) begin
               fpos = 0;
               case (phase)
                  PH_MAGIC: begin
                     if (shift != magic_reg) flag(ST_MAGIC);
                     phase = PH_VER;
                  end
                  PH_VER: begin
                     if (shift[31:16] != version_reg[15:0]) flag(ST_VERSION);
                     phase = PH_LEN;
                  end
                  PH_LEN: begin
                     len_v = shift[31:16]; phase = PH_EPOCH;
                  end
                  PH_EPOCH: begin
                     epoch_v = shift; phase = PH_NEXT;
                  end
                  PH_NEXT: begin
                     next_v = shift; phase = PH_COUNT;
                  end
                  PH_COUNT: begin
                     count_v = shift[31:16];
                     if (count_v > max_reg) begin
                        flag(ST_MANY); phase = PH_SKIP;
                     end else begin
                        if (len_v != 16'(FIXED_BYTES + count_v * 8)) flag(ST_LENGTH);
                        phase = (count_v == 0) ? PH_TAIL : PH_RSTART;
                     end
                  end
                  PH_RSTART: begin
                     pend_start = shift; phase = PH_REND;
                  end
                  PH_REND: begin
                     if (pend_start == 0) flag(ST_START0);
                     else if (shift < pend_start) flag(ST_ORDER);
                     if (err == ST_OK) push(0, done_cnt, pend_start, shift, ST_OK, 0);
                     done_cnt = done_cnt + 1;
                     phase = ({3'd0, done_cnt} == count_v) ? PH_TAIL : PH_RSTART;
                  end
                  PH_TAIL: begin
                     tail_v = shift;
                     if (tail_v == 0 && count_v != 0) flag(ST_TAIL0);
                     crc_tail = ~crc; phase = PH_CRC;
                  end
                  PH_CRC: begin
                     if (shift != crc_tail) flag(ST_CRC);
                     phase = PH_FOOTER;
                  end
                  default: begin
                     if (shift != footer_reg) flag(ST_FOOTER);
                     phase = PH_DONE;
                  end
               endcase
            end
         end
         if (last) begin
            if (nbytes < FIXED_BYTES) st = ST_SHORT;
            else if (err >= ST_MAGIC && err <= ST_LENGTH) st = err;
            else if (nbytes != {1'b0, len_v}) st = ST_SIZE;
            else st = err;
            push(1, 0, 0, 0, st, tail_v);
            clear_record();
         end
         if (pending_results.size() > n0)
            pending_results[pending_results.size() - 1].final_res = 1;
      endfunction

      function void check_result(manifest_result_type got);
         manifest_result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result kind %0d status %0d", $realtime, got.kind,
                     got.status);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [7:0]   req_tdata = 0;
   logic         req_tlast = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [199:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we = 0;
   logic [1:0]   csr_index = 0;
   logic [31:0]  csr_wdata = 0;

   manifest_scoreboard board = new();
   logic [7:0] rec_bytes[$];
   int idle_cycles = 0;
   int gap_left = 0;

   manifest_record_validator dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      manifest_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.index = rsp_tdata[12:0];     got.rstart = rsp_tdata[44:13];
         got.rend = rsp_tdata[76:45];     got.status = rsp_tdata[80:77];
         got.epoch = rsp_tdata[112:81];   got.next_gen = rsp_tdata[144:113];
         got.tail_gen = rsp_tdata[176:145]; got.total = rsp_tdata[192:177];
         got.kind = rsp_tuser;            got.final_res = rsp_tlast;
         board.check_result(got);
      end
      if (!reset && req_tvalid && req_tready) board.note_byte(req_tdata, req_tlast);
      // Receiver stalls in a slowly changing pattern with long ready stretches.
      rsp_tready <= ($urandom_range(0, 99) < ((($time / 500) % 3 == 0) ? 100 : 65));
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 3000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_byte(logic [7:0] b, logic last);
      if (gap_left == 0 && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         gap_left = $urandom_range(1, 40);
      end
      if (gap_left > 0) gap_left--;
      req_tvalid <= 1; req_tdata <= b; req_tlast <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_record();
      for (int i = 0; i < rec_bytes.size(); i++)
         send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] v);
      csr_we <= 1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      board.write_reg(idx, v);
      csr_we <= 0;
   endtask

   function automatic void add_word(logic [31:0] v, int nb);
      for (int i = 0; i < nb; i++) rec_bytes = {rec_bytes, v[8*i +: 8]};
   endfunction

   // Builds a record; corrupt selects one fault to inject (0 none).
   function automatic void build_record(int nranges, int corrupt);
      logic [31:0] c, s, e;
      rec_bytes.delete();
      add_word(corrupt == 1 ? ~board.magic_reg : board.magic_reg, 4);
      add_word(corrupt == 2 ? board.version_reg ^ 32'd1 : board.version_reg, 2);
      add_word(32'(FIXED_BYTES + nranges * 8 + (corrupt == 3 ? 8 : 0)), 2);
      add_word($urandom, 4);
      add_word($urandom, 4);
      add_word(32'(nranges), 2);
      for (int r = 0; r < nranges; r++) begin
         s = $urandom_range(0, 3) == 0 ? $urandom_range(1, 9) : $urandom | 1;
         e = (corrupt == 5 && r == nranges - 1) ? s - 1 : s + $urandom_range(0, 1000);
         if (e < s && corrupt != 5) e = 32'hFFFFFFFF;
         if (corrupt == 4 && r == 0) s = 0;
         add_word(s, 4); add_word(e, 4);
      end
      add_word(corrupt == 6 ? 32'd0 : ($urandom | 32'h100), 4);
      c = '1;
      foreach (rec_bytes[i]) begin
         c = c ^ {24'd0, rec_bytes[i]};
         for (int k = 0; k < 8; k++) c = (c >> 1) ^ (c[0] ? 32'hEDB88320 : 32'd0);
      end
      add_word(corrupt == 7 ? c : ~c, 4);
      add_word(corrupt == 8 ? ~board.footer_reg : board.footer_reg, 4);
      if (corrupt == 9) rec_bytes = {rec_bytes, 8'($urandom)};
      if (corrupt == 10) rec_bytes = rec_bytes[0:$urandom_range(0, 28)];
      if (corrupt == 11) rec_bytes = rec_bytes[0:$urandom_range(29, rec_bytes.size() - 2)];
      if (corrupt == 12) foreach (rec_bytes[i]) rec_bytes[i] = 8'($urandom);
   endfunction

   initial begin
      int sent;
      board.reset_all();
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: reset registers, then extreme settings and each fault.
      build_record(0, 0); send_record();
      build_record(1, 0); send_record();
      drain();
      write_csr(CSR_MAGIC, 32'hFFFFFFFF); write_csr(CSR_VERSION, 32'hFFFF);
      write_csr(CSR_FOOTER, 32'hFFFFFFFF); write_csr(CSR_MAXRNG, 32'd0);
      build_record(0, 0); send_record();
      build_record(1, 0); send_record();
      send_byte(8'hFF, 1);
      drain();
      write_csr(CSR_MAGIC, 32'h4D414E49); write_csr(CSR_VERSION, 32'd3);
      write_csr(CSR_FOOTER, 32'h454E4421); write_csr(CSR_MAXRNG, 32'd3);
      for (int k = 1; k <= 12; k++) begin
         build_record(k == 6 ? 1 : 2, k); send_record();
      end
      build_record(3, 0); send_record();
      build_record(4, 0); send_record();
      drain();
      sent = 0;
      for (int phase_n = 0; phase_n < 4; phase_n++) begin
         case (phase_n)
            0: write_csr(CSR_MAXRNG, 32'd8187);
            1: write_csr(CSR_MAXRNG, 32'd2);
            2: begin write_csr(CSR_MAGIC, $urandom); write_csr(CSR_FOOTER, $urandom); end
            default: write_csr(CSR_VERSION, $urandom);
         endcase
         for (int q = 0; q < 20; q += rec_bytes.size()) begin
            int k;
            k = $urandom_range(0, 99);
            build_record($urandom_range(0, 4), k < 60 ? 0 : $urandom_range(1, 12));
            send_record();
            sent += rec_bytes.size();
         end
         drain();
      end
      repeat (10) @(posedge clock);
      if (board.errors == 0 && board.pending_results.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

// File: files.f
rtl/mrv_pkg.sv
rtl/mrv_parser.sv
rtl/mrv_queue.sv
rtl/manifest_record_validator.sv
bench/manifest_record_validator_tb.sv
